@@ design/btc_pkg.sv @@
// Shared types and constants for the banded thermostat controller.
`default_nettype none

package btc_pkg;

    localparam int unsigned TEMP_W  = 11;
    localparam int unsigned INNER_W = 7;
    localparam int unsigned OUTER_W = 9;
    localparam int unsigned HOLD_W  = 10;
    localparam int unsigned ZONE_W  = 3;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [ZONE_W-1:0] ZONE_HOLDING   = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_BALANCED  = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_NEAR_LOW  = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_FAR_LOW   = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_NEAR_HIGH = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_FAR_HIGH  = 3'd5;
    localparam logic [ZONE_W-1:0] ZONE_DISABLED  = 3'd6;

    localparam logic [ADDR_W-1:0] ADDR_ENABLE     = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_SETPOINT   = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_INNER_BAND = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_OUTER_BAND = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_LONG_HOLD  = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_SHORT_HOLD = 5'd20;

    localparam logic signed [TEMP_W-1:0] SETPOINT_RST   = 11'sd250;
    localparam logic [INNER_W-1:0]       INNER_BAND_RST = 7'd5;
    localparam logic [OUTER_W-1:0]       OUTER_BAND_RST = 9'd30;
    localparam logic [HOLD_W-1:0]        LONG_HOLD_RST  = 10'd300;
    localparam logic [HOLD_W-1:0]        SHORT_HOLD_RST = 10'd150;

    typedef struct packed {
        logic                       enable;
        logic signed [TEMP_W-1:0]   setpoint;
        logic [INNER_W-1:0]         inner_band;
        logic [OUTER_W-1:0]         outer_band;
        logic [HOLD_W-1:0]          long_hold;
        logic [HOLD_W-1:0]          short_hold;
    } cfg_t;

endpackage

`default_nettype wire

@@ design/btc_regs.sv @@
// Configuration register file with APB-style access.
`default_nettype none

module btc_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [btc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [btc_pkg::DATA_W-1:0]    pwdata,
    output logic      [btc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output btc_pkg::cfg_t                      cfg
);

    btc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.setpoint   <= btc_pkg::SETPOINT_RST;
            cfg_reg.inner_band <= btc_pkg::INNER_BAND_RST;
            cfg_reg.outer_band <= btc_pkg::OUTER_BAND_RST;
            cfg_reg.long_hold  <= btc_pkg::LONG_HOLD_RST;
            cfg_reg.short_hold <= btc_pkg::SHORT_HOLD_RST;
        end
        else if (wr_en)
        begin
            case (paddr)
                btc_pkg::ADDR_ENABLE:     cfg_reg.enable     <= pwdata[0];
                btc_pkg::ADDR_SETPOINT:   cfg_reg.setpoint   <= pwdata[btc_pkg::TEMP_W-1:0];
                btc_pkg::ADDR_INNER_BAND: cfg_reg.inner_band <= pwdata[btc_pkg::INNER_W-1:0];
                btc_pkg::ADDR_OUTER_BAND: cfg_reg.outer_band <= pwdata[btc_pkg::OUTER_W-1:0];
                btc_pkg::ADDR_LONG_HOLD:  cfg_reg.long_hold  <= pwdata[btc_pkg::HOLD_W-1:0];
                btc_pkg::ADDR_SHORT_HOLD: cfg_reg.short_hold <= pwdata[btc_pkg::HOLD_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr)
            btc_pkg::ADDR_ENABLE:     prdata[0] = cfg_reg.enable;
            btc_pkg::ADDR_SETPOINT:
                prdata = {{(btc_pkg::DATA_W-btc_pkg::TEMP_W){cfg_reg.setpoint[btc_pkg::TEMP_W-1]}},
                          cfg_reg.setpoint};
            btc_pkg::ADDR_INNER_BAND: prdata[btc_pkg::INNER_W-1:0] = cfg_reg.inner_band;
            btc_pkg::ADDR_OUTER_BAND: prdata[btc_pkg::OUTER_W-1:0] = cfg_reg.outer_band;
            btc_pkg::ADDR_LONG_HOLD:  prdata[btc_pkg::HOLD_W-1:0]  = cfg_reg.long_hold;
            btc_pkg::ADDR_SHORT_HOLD: prdata[btc_pkg::HOLD_W-1:0]  = cfg_reg.short_hold;
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/banded_thermostat_controller.sv @@
// Top level of the banded thermostat controller: input stage, band logic, result stage.
`default_nettype none

// Each input beat is one control period: a temperature sample in tenths of a
// degree and a setpoint-changed flag. The beat is captured in an input register,
// sorted into a band and applied to the heating, cooling, balanced, aux and hold
// state, and the result lands in an output register. One beat per cycle is
// sustained while m_tready is high. While a result waits on m_tready the input
// register still takes one beat, then s_tready drops until the result drains.
// Write configuration only while idle.

module banded_thermostat_controller
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [10:0] temperature
    input  wire logic                          s_tuser,   // [0] setpoint_changed
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata,   // [0] heater_on, [1] cooler_on,
                                                          // [2] fans_on, [3] pump_on, [6:4] zone
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [btc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [btc_pkg::DATA_W-1:0]    pwdata,
    output logic      [btc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int unsigned CMP_W = btc_pkg::TEMP_W + 2;

    btc_pkg::cfg_t cfg;

    btc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                               in_valid_reg;
    logic signed [btc_pkg::TEMP_W-1:0]  in_temp_reg;
    logic                               in_flag_reg;
    logic                               out_valid_reg;
    logic [7:0]                         out_data_reg;
    logic                               advance;

    logic                               heating_reg, heating_next;
    logic                               cooling_reg, cooling_next;
    logic                               balanced_reg, balanced_next;
    logic                               aux_reg, aux_next;
    logic [btc_pkg::HOLD_W-1:0]         hold_left_reg, hold_left_next;
    logic                               brk_reg, brk_next;
    logic [btc_pkg::ZONE_W-1:0]         zone_next;

    logic signed [CMP_W-1:0]            t_w, s_w, ib_w, ob_w;
    logic signed [CMP_W-1:0]            lo_i, hi_i, lo_o, hi_o;
    logic                               in_bal, in_near_lo, in_far_lo, in_near_hi;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign t_w  = CMP_W'(in_temp_reg);
    assign s_w  = CMP_W'(cfg.setpoint);
    assign ib_w = signed'(CMP_W'(cfg.inner_band));
    assign ob_w = signed'(CMP_W'(cfg.outer_band));
    assign lo_i = s_w - ib_w;
    assign hi_i = s_w + ib_w;
    assign lo_o = s_w - ob_w;
    assign hi_o = s_w + ob_w;

    assign in_bal     = (lo_i <= t_w) && (t_w <= hi_i);
    assign in_near_lo = (lo_o < t_w) && (t_w < lo_i);
    assign in_far_lo  = (t_w <= lo_o);
    assign in_near_hi = (hi_i < t_w) && (t_w < hi_o);

    always_comb
    begin
        logic brk_w;
        heating_next   = heating_reg;
        cooling_next   = cooling_reg;
        balanced_next  = balanced_reg;
        aux_next       = aux_reg;
        hold_left_next = hold_left_reg;
        brk_next       = brk_reg;
        zone_next      = btc_pkg::ZONE_HOLDING;
        brk_w          = brk_reg || in_flag_reg;

        if (!cfg.enable)
        begin
            heating_next   = 1'b0;
            cooling_next   = 1'b0;
            balanced_next  = 1'b0;
            aux_next       = 1'b0;
            hold_left_next = '0;
            brk_next       = 1'b0;
            zone_next      = btc_pkg::ZONE_DISABLED;
        end
        else if (hold_left_reg != '0 && !brk_w)
        begin
            hold_left_next = hold_left_reg - 1'b1;
            brk_next       = brk_w;
            zone_next      = btc_pkg::ZONE_HOLDING;
        end
        else
        begin
            if (hold_left_reg != '0)
            begin
                brk_w          = 1'b0;
                hold_left_next = '0;
            end
            brk_next = brk_w;
            if (in_bal)
            begin
                zone_next     = btc_pkg::ZONE_BALANCED;
                balanced_next = 1'b1;
                heating_next  = 1'b0;
                cooling_next  = 1'b0;
                aux_next      = 1'b0;
                if (brk_w)
                begin
                    brk_next       = 1'b0;
                    hold_left_next = '0;
                end
                else
                begin
                    hold_left_next = cfg.long_hold;
                end
            end
            else if (in_near_lo || in_near_hi)
            begin
                zone_next = in_near_lo ? btc_pkg::ZONE_NEAR_LOW : btc_pkg::ZONE_NEAR_HIGH;
                if (balanced_reg)
                begin
                    if (brk_w)
                    begin
                        brk_next       = 1'b0;
                        hold_left_next = '0;
                    end
                    else
                    begin
                        hold_left_next = cfg.short_hold;
                    end
                end
                else if (in_near_lo && !heating_reg)
                begin
                    heating_next = 1'b1;
                    aux_next     = 1'b1;
                end
                else if (in_near_hi && !cooling_reg)
                begin
                    cooling_next = 1'b1;
                    aux_next     = 1'b1;
                end
            end
            else if (in_far_lo)
            begin
                zone_next = btc_pkg::ZONE_FAR_LOW;
                if (!heating_reg)
                begin
                    heating_next  = 1'b1;
                    aux_next      = 1'b1;
                    balanced_next = 1'b0;
                end
            end
            else
            begin
                zone_next = btc_pkg::ZONE_FAR_HIGH;
                if (!cooling_reg)
                begin
                    cooling_next  = 1'b1;
                    aux_next      = 1'b1;
                    balanced_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            heating_reg   <= 1'b0;
            cooling_reg   <= 1'b0;
            balanced_reg  <= 1'b0;
            aux_reg       <= 1'b0;
            hold_left_reg <= '0;
            brk_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                heating_reg   <= heating_next;
                cooling_reg   <= cooling_next;
                balanced_reg  <= balanced_next;
                aux_reg       <= aux_next;
                hold_left_reg <= hold_left_next;
                brk_reg       <= brk_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_temp_reg <= s_tdata[btc_pkg::TEMP_W-1:0];
            in_flag_reg <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, zone_next, aux_next, aux_next, cooling_next, heating_next};
        end
    end

    a_heat_aux: assert property (@(posedge clk) disable iff (!rst_n)
        heating_reg |-> aux_reg)
        else $error("heating without aux");

    a_cool_aux: assert property (@(posedge clk) disable iff (!rst_n)
        cooling_reg |-> aux_reg)
        else $error("cooling without aux");

    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg.enable) |=>
            (out_data_reg == {1'b0, btc_pkg::ZONE_DISABLED, 4'b0000}) && (hold_left_reg == '0))
        else $error("disabled beat left state or outputs set");

    a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cfg.enable && hold_left_reg != '0 && !brk_reg && !in_flag_reg) |=>
            (hold_left_reg == $past(hold_left_reg) - 1'b1) &&
            (out_data_reg[6:4] == btc_pkg::ZONE_HOLDING))
        else $error("hold count did not step down");

endmodule

`default_nettype wire

@@ bench/banded_thermostat_controller_tb.sv @@
// Self-checking bench for the banded thermostat controller: directed rows, then random phases.

module banded_thermostat_controller_tb;

    import btc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic              pump;
        logic              fans;
        logic              cooler;
        logic              heater;
    } drive_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [ADDR_W-1:0]        addr;
        logic [DATA_W-1:0]        value;
        logic signed [TEMP_W-1:0] temp;
        logic                     chg;
        logic                     typed;
        drive_t                   want;
    } plan_row_t;

    localparam drive_t RES_DISABLED = '{ZONE_DISABLED, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam drive_t RES_HEAT_FAR = '{ZONE_FAR_LOW, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam drive_t RES_BOTH_FAR = '{ZONE_FAR_HIGH, 1'b1, 1'b1, 1'b1, 1'b1};

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // [10:0] temperature
    logic              s_tuser  = 1'b0; // [0] setpoint_changed
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // [0] heater_on, [1] cooler_on, [2] fans_on,
                                        // [3] pump_on, [6:4] zone
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cfg_t              shadow = '{1'b0, SETPOINT_RST, INNER_BAND_RST, OUTER_BAND_RST,
                                  LONG_HOLD_RST, SHORT_HOLD_RST};
    logic              heat_flag   = 1'b0;
    logic              cool_flag   = 1'b0;
    logic              bal_flag    = 1'b0;
    logic              aux_flag    = 1'b0;
    logic [HOLD_W-1:0] hold_left   = '0;
    logic              brk_pending = 1'b0;

    drive_t            pending_drive[$];
    plan_row_t         plan[$];
    int                cycle_count   = 0;
    int                mismatches    = 0;
    int                beats_sent    = 0;
    int                results_seen  = 0;
    int                settings_used = 1;
    int                hold_off_req  = 0;
    int                rx_stall      = 0;
    int                rx_gap        = 0;
    logic              tx_idle_on    = 1'b1;
    logic              rx_idle_on    = 1'b1;

    banded_thermostat_controller dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void begin_hold(input logic [HOLD_W-1:0] len);
        if (brk_pending)
        begin
            brk_pending = 1'b0;
            hold_left   = '0;
        end
        else
        begin
            hold_left = len;
        end
    endfunction

    function automatic drive_t control_period(input logic signed [TEMP_W-1:0] temp,
                                              input logic chg);
        drive_t d;
        int     t;
        int     s;
        int     ib;
        int     ob;
        t  = temp;
        s  = $signed(shadow.setpoint);
        ib = shadow.inner_band;
        ob = shadow.outer_band;
        d  = RES_DISABLED;
        if (!shadow.enable)
        begin
            heat_flag   = 1'b0;
            cool_flag   = 1'b0;
            bal_flag    = 1'b0;
            aux_flag    = 1'b0;
            hold_left   = '0;
            brk_pending = 1'b0;
            return RES_DISABLED;
        end
        if (chg)
            brk_pending = 1'b1;
        if (hold_left != 0 && !brk_pending)
        begin
            hold_left = hold_left - 1'b1;
            d.zone    = ZONE_HOLDING;
        end
        else
        begin
            if (hold_left != 0)
            begin
                brk_pending = 1'b0;
                hold_left   = '0;
            end
            if (s - ib <= t && t <= s + ib)
            begin
                d.zone    = ZONE_BALANCED;
                bal_flag  = 1'b1;
                heat_flag = 1'b0;
                cool_flag = 1'b0;
                aux_flag  = 1'b0;
                begin_hold(shadow.long_hold);
            end
            else if (s - ob < t && t < s - ib)
            begin
                d.zone = ZONE_NEAR_LOW;
                if (bal_flag)
                    begin_hold(shadow.short_hold);
                else if (!heat_flag)
                begin
                    heat_flag = 1'b1;
                    aux_flag  = 1'b1;
                end
            end
            else if (t <= s - ob)
            begin
                d.zone = ZONE_FAR_LOW;
                if (!heat_flag)
                begin
                    heat_flag = 1'b1;
                    aux_flag  = 1'b1;
                    bal_flag  = 1'b0;
                end
            end
            else if (s + ib < t && t < s + ob)
            begin
                d.zone = ZONE_NEAR_HIGH;
                if (bal_flag)
                    begin_hold(shadow.short_hold);
                else if (!cool_flag)
                begin
                    cool_flag = 1'b1;
                    aux_flag  = 1'b1;
                end
            end
            else
            begin
                d.zone = ZONE_FAR_HIGH;
                if (!cool_flag)
                begin
                    cool_flag = 1'b1;
                    aux_flag  = 1'b1;
                    bal_flag  = 1'b0;
                end
            end
        end
        d.heater = heat_flag;
        d.cooler = cool_flag;
        d.fans   = aux_flag;
        d.pump   = aux_flag;
        return d;
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int s;
        int ib;
        int ob;
        int off;
        int span;
        int t;
        s    = $signed(shadow.setpoint);
        ib   = shadow.inner_band;
        ob   = shadow.outer_band;
        span = ib + ob + 16;
        case ($urandom_range(0, 9))
            0: t = int'($urandom);
            1, 2:
            begin
                case ($urandom_range(0, 3))
                    0:       off = ib;
                    1:       off = ib + 1;
                    2:       off = ob;
                    default: off = ob - 1;
                endcase
                t = $urandom_range(0, 1) ? s + off : s - off;
            end
            default: t = s + int'($urandom_range(0, 2 * span)) - span;
        endcase
        return t[TEMP_W-1:0];
    endfunction

    task automatic add_beat(input int temp, input logic chg, input logic typed,
                            input drive_t want);
        plan_row_t r;
        r.kind  = ROW_BEAT;
        r.addr  = '0;
        r.value = '0;
        r.temp  = temp[TEMP_W-1:0];
        r.chg   = chg;
        r.typed = typed;
        r.want  = want;
        plan.insert(plan.size(), r);
    endtask

    task automatic add_reg(input logic [ADDR_W-1:0] addr, input int value);
        plan_row_t r;
        r.kind  = ROW_REG;
        r.addr  = addr;
        r.value = value;
        r.temp  = '0;
        r.chg   = 1'b0;
        r.typed = 1'b0;
        r.want  = '0;
        plan.insert(plan.size(), r);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_ENABLE:     shadow.enable     = data[0];
            ADDR_SETPOINT:   shadow.setpoint   = data[TEMP_W-1:0];
            ADDR_INNER_BAND: shadow.inner_band = data[INNER_W-1:0];
            ADDR_OUTER_BAND: shadow.outer_band = data[OUTER_W-1:0];
            ADDR_LONG_HOLD:  shadow.long_hold  = data[HOLD_W-1:0];
            ADDR_SHORT_HOLD: shadow.short_hold = data[HOLD_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_beat(input logic signed [TEMP_W-1:0] temp, input logic chg,
                             input logic typed, input drive_t want);
        drive_t predicted;
        int     gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - TEMP_W){1'b0}}, temp};
        s_tuser  <= chg;
        do @(posedge clk); while (!s_tready);
        predicted = control_period(temp, chg);
        pending_drive.insert(pending_drive.size(), typed ? want : predicted);
        beats_sent++;
    endtask

    task automatic report_field(input string field, input int want, input int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // hold m_tready low for requested long stalls and random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req > 0)
            begin
                rx_stall     = hold_off_req;
                hold_off_req = 0;
            end
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                rx_gap = $urandom_range(1, 14) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        drive_t got;
        drive_t want;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata[6:0];
                results_seen++;
                if (pending_drive.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = pending_drive.pop_front();
                    if (got.heater !== want.heater) report_field("heater_on", want.heater, got.heater);
                    if (got.cooler !== want.cooler) report_field("cooler_on", want.cooler, got.cooler);
                    if (got.fans !== want.fans)     report_field("fans_on", want.fans, got.fans);
                    if (got.pump !== want.pump)     report_field("pump_on", want.pump, got.pump);
                    if (got.zone !== want.zone)     report_field("zone", want.zone, got.zone);
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d results still expected", $time, pending_drive.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int   phase;
        int   k;
        int   n;
        int   en;
        int   sp;
        int   ib;
        int   ob;
        int   lh;
        int   sh;
        logic chg;

        add_beat(-1024, 1'b1, 1'b1, RES_DISABLED);
        add_beat(1023, 1'b0, 1'b1, RES_DISABLED);
        add_reg(ADDR_LONG_HOLD, 2);
        add_reg(ADDR_SHORT_HOLD, 1);
        add_reg(ADDR_ENABLE, 1);
        add_beat(-1024, 1'b0, 1'b1, RES_HEAT_FAR);
        add_beat(1023, 1'b0, 1'b1, RES_BOTH_FAR);
        add_beat(250, 1'b0, 1'b0, '0);
        add_beat(230, 1'b0, 1'b0, '0);
        add_beat(230, 1'b0, 1'b0, '0);
        add_beat(230, 1'b0, 1'b0, '0);
        add_beat(300, 1'b0, 1'b0, '0);
        add_beat(260, 1'b0, 1'b0, '0);
        add_beat(260, 1'b1, 1'b0, '0);
        add_beat(200, 1'b1, 1'b0, '0);
        add_beat(240, 1'b0, 1'b0, '0);
        add_beat(270, 1'b0, 1'b0, '0);
        add_beat(255, 1'b0, 1'b0, '0);
        add_beat(245, 1'b0, 1'b0, '0);
        add_beat(245, 1'b0, 1'b0, '0);
        add_beat(245, 1'b1, 1'b0, '0);
        add_beat(280, 1'b0, 1'b0, '0);
        add_beat(220, 1'b0, 1'b0, '0);
        add_reg(ADDR_LONG_HOLD, 0);
        add_reg(ADDR_INNER_BAND, 100);
        add_beat(350, 1'b0, 1'b0, '0);
        add_beat(351, 1'b0, 1'b0, '0);
        add_beat(150, 1'b0, 1'b0, '0);
        add_beat(149, 1'b0, 1'b0, '0);
        add_reg(ADDR_ENABLE, 0);
        add_beat(250, 1'b1, 1'b1, RES_DISABLED);
        add_reg(ADDR_ENABLE, 1);
        add_beat(250, 1'b0, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain(4);
                reg_write(plan[i].addr, plan[i].value);
            end
            else
            begin
                send_beat(plan[i].temp, plan[i].chg, plan[i].typed, plan[i].want);
            end
        end

        for (phase = 0; phase < 10; phase++)
        begin
            en = 1;
            sp = int'($urandom_range(0, 1200)) - 400;
            ib = $urandom_range(0, 3) == 0 ? $urandom_range(0, 100) : $urandom_range(0, 20);
            ob = $urandom_range(0, 3) == 0 ? $urandom_range(0, 500) : $urandom_range(0, 60);
            lh = $urandom_range(0, 4) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 6);
            sh = $urandom_range(0, 4) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 4);
            case (phase)
                0:
                begin
                    sp = -1024;
                    ib = 0;
                    ob = 0;
                    lh = 0;
                    sh = 0;
                end
                1:
                begin
                    sp = 1023;
                    ib = 127;
                    ob = 511;
                    lh = 1023;
                    sh = 1023;
                end
                3: en = 0;
                default: ;
            endcase
            drain(4);
            reg_write(ADDR_ENABLE, en);
            reg_write(ADDR_SETPOINT, sp & 32'h7FF);
            reg_write(ADDR_INNER_BAND, ib);
            reg_write(ADDR_OUTER_BAND, ob);
            reg_write(ADDR_LONG_HOLD, lh);
            reg_write(ADDR_SHORT_HOLD, sh);
            settings_used++;
            tx_idle_on = (phase != 2 && phase != 9);
            rx_idle_on = (phase != 2 && phase != 9);
            if (phase == 2)
                hold_off_req = 80;
            n = (phase == 3) ? 40 : 160;
            for (k = 0; k < n; k++)
            begin
                if (phase == 2 && k == 100)
                    drain(0);
                chg = ($urandom_range(0, 11) == 0);
                send_beat(pick_temp(), chg, 1'b0, '0);
            end
        end

        drain(8);
        $display("Covered %0d beats and %0d results over %0d register settings,", beats_sent,
                 results_seen, settings_used);
        $display("including range extremes, a disabled phase, a long output stall and a pause.");
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
design/btc_pkg.sv
design/btc_regs.sv
design/banded_thermostat_controller.sv
bench/banded_thermostat_controller_tb.sv
